[rtl/pcmc_pkg.sv]
// ---------------------------------------------------------------------------
// pcmc_pkg
// Shared types, command codes and motor pin patterns of the patrol car
// motion controller.
// ---------------------------------------------------------------------------
package pcmc_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CMD_W   = 8;
  localparam int unsigned PINS_W  = 8;
  localparam int unsigned PHASE_W = 4;
  localparam int unsigned CIDX_W  = 2;

  // register indexes on the configuration port
  localparam logic [CIDX_W-1:0] CFG_FORWARD_TIME = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_TURN_TIME    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd2;

  localparam logic [CFG_W-1:0] FORWARD_TIME_RST = 16'd4000;
  localparam logic [CFG_W-1:0] TURN_TIME_RST    = 16'd1700;
  localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST = 16'd500;

  // ascii command bytes
  localparam logic [CMD_W-1:0] CMD_FORWARD    = 8'h77; // w
  localparam logic [CMD_W-1:0] CMD_BACKWARD   = 8'h73; // s
  localparam logic [CMD_W-1:0] CMD_LEFT       = 8'h61; // a
  localparam logic [CMD_W-1:0] CMD_RIGHT      = 8'h64; // d
  localparam logic [CMD_W-1:0] CMD_STOP       = 8'h6A; // j
  localparam logic [CMD_W-1:0] CMD_PATROL     = 8'h70; // p
  localparam logic [CMD_W-1:0] CMD_EXTINGUISH = 8'h45; // E

  // bits 7..0: LFF LBF RFF RBF LFB LBB RFB RBB
  localparam logic [PINS_W-1:0] PINS_STOP     = 8'h00;
  localparam logic [PINS_W-1:0] PINS_FORWARD  = 8'hF0;
  localparam logic [PINS_W-1:0] PINS_BACKWARD = 8'h0F;
  localparam logic [PINS_W-1:0] PINS_RIGHT    = 8'hC0;
  localparam logic [PINS_W-1:0] PINS_LEFT     = 8'h30;

  localparam logic [PHASE_W-1:0] PHASE_STOPPED   = 4'd0;
  localparam logic [PHASE_W-1:0] PHASE_FIRST_LEG = 4'd1;
  localparam logic [PHASE_W-1:0] PHASE_LAST_TURN = 4'd8;

  typedef struct packed {
    logic [CFG_W-1:0] forward_time_ms;
    logic [CFG_W-1:0] turn_time_ms;
    logic [CFG_W-1:0] idle_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              flame_seen;
    logic              cmd_present;
    logic [CMD_W-1:0]  cmd_byte;
    logic              rx_idle;
  } item_t;

  typedef struct packed {
    logic [PINS_W-1:0]  motor_pins;
    logic               buzzer_on;
    logic               fire_alert;
    logic               extinguish_req;
    logic               patrol_on;
    logic [PHASE_W-1:0] patrol_phase;
  } result_t;

  typedef struct packed {
    logic               patrol_active;
    logic [PHASE_W-1:0] phase;
    logic [TIME_W-1:0]  phase_start_ms;
    logic [TIME_W-1:0]  last_cmd_ms;
    logic               flame_prev;
    logic               buzzer_state;
    logic [PINS_W-1:0]  motor_state;
  } state_t;

endpackage

[rtl/pcmc_ifs.sv]
// ---------------------------------------------------------------------------
// pcmc channel interfaces
// Valid/ready channels for pass items, results and register writes.
// ---------------------------------------------------------------------------
interface pcmc_in_if import pcmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ms;
  logic              flame_seen;
  logic              cmd_present;
  logic [CMD_W-1:0]  cmd_byte;
  logic              rx_idle;

  modport source (output valid, now_ms, flame_seen, cmd_present, cmd_byte, rx_idle,
                  input ready);
  modport sink (input valid, now_ms, flame_seen, cmd_present, cmd_byte, rx_idle,
                output ready);
endinterface

interface pcmc_out_if import pcmc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PINS_W-1:0]  motor_pins;
  logic               buzzer_on;
  logic               fire_alert;
  logic               extinguish_req;
  logic               patrol_on;
  logic [PHASE_W-1:0] patrol_phase;

  modport source (output valid, motor_pins, buzzer_on, fire_alert, extinguish_req,
                  patrol_on, patrol_phase, input ready);
  modport sink (input valid, motor_pins, buzzer_on, fire_alert, extinguish_req,
                patrol_on, patrol_phase, output ready);
endinterface

interface pcmc_cfg_if import pcmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CFG_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/pcmc_cfg_regs.sv]
// ---------------------------------------------------------------------------
// pcmc_cfg_regs
// Leg, turn and idle timeout registers behind the write channel.
// ---------------------------------------------------------------------------
module pcmc_cfg_regs import pcmc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pcmc_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.forward_time_ms <= FORWARD_TIME_RST;
      cfg_r.turn_time_ms    <= TURN_TIME_RST;
      cfg_r.idle_timeout_ms <= IDLE_TIMEOUT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_FORWARD_TIME: cfg_r.forward_time_ms <= cfg_ch.data;
        CFG_TURN_TIME:    cfg_r.turn_time_ms    <= cfg_ch.data;
        CFG_IDLE_TIMEOUT: cfg_r.idle_timeout_ms <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/pcmc_step.sv]
// ---------------------------------------------------------------------------
// pcmc_step
// One control-loop pass: flame edges, patrol sequencer, command decode and
// manual idle watchdog, as next-state and result logic.
// ---------------------------------------------------------------------------
module pcmc_step import pcmc_pkg::*; (
  input  state_t  st,
  input  item_t   item,
  input  cfg_t    cfg,
  output state_t  st_nxt,
  output result_t res
);

  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] idle_gap;
  logic              alert;
  logic              extinguish;
  state_t            s;

  assign elapsed = item.now_ms - st.phase_start_ms;

  always_comb begin
    s          = st;
    alert      = 1'b0;
    extinguish = 1'b0;

    // flame edges
    if (item.flame_seen && !st.flame_prev && st.patrol_active) begin
      s.buzzer_state  = 1'b1;
      alert           = 1'b1;
      s.patrol_active = 1'b0;
      s.phase         = PHASE_STOPPED;
      s.motor_state   = PINS_STOP;
    end else if (!item.flame_seen && st.flame_prev) begin
      s.buzzer_state = 1'b0;
    end
    s.flame_prev = item.flame_seen;

    // patrol sequencer, phase start is not touched by the flame step
    if (s.patrol_active && s.phase != PHASE_STOPPED && s.phase <= PHASE_LAST_TURN) begin
      if (s.phase[0]) begin
        if (elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.forward_time_ms}) begin
          s.phase          = s.phase + 4'd1;
          s.phase_start_ms = item.now_ms;
          s.motor_state    = PINS_RIGHT;
        end
      end else begin
        if (elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.turn_time_ms}) begin
          s.phase          = (s.phase == PHASE_LAST_TURN) ? PHASE_FIRST_LEG
                                                          : s.phase + 4'd1;
          s.phase_start_ms = item.now_ms;
          s.motor_state    = PINS_FORWARD;
        end
      end
    end

    // command decode
    if (item.cmd_present) begin
      s.last_cmd_ms = item.now_ms;
      if (item.cmd_byte != CMD_PATROL && s.patrol_active) begin
        s.patrol_active = 1'b0;
        s.phase         = PHASE_STOPPED;
      end
      unique case (item.cmd_byte)
        CMD_FORWARD: begin
          s.buzzer_state = 1'b0;
          s.motor_state  = PINS_FORWARD;
        end
        CMD_BACKWARD: begin
          s.buzzer_state = 1'b0;
          s.motor_state  = PINS_BACKWARD;
        end
        CMD_LEFT: begin
          s.buzzer_state = 1'b0;
          s.motor_state  = PINS_LEFT;
        end
        CMD_RIGHT: begin
          s.buzzer_state = 1'b0;
          s.motor_state  = PINS_RIGHT;
        end
        CMD_STOP: begin
          s.buzzer_state = 1'b0;
          s.motor_state  = PINS_STOP;
        end
        CMD_PATROL: begin
          if (!s.patrol_active) begin
            s.patrol_active  = 1'b1;
            s.phase          = PHASE_FIRST_LEG;
            s.phase_start_ms = item.now_ms;
            s.motor_state    = PINS_FORWARD;
          end
        end
        CMD_EXTINGUISH: begin
          s.buzzer_state = 1'b0;
          extinguish     = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // watchdog sees last_cmd_ms after the command step
  assign idle_gap = item.now_ms - s.last_cmd_ms;

  always_comb begin
    st_nxt = s;
    if (!s.patrol_active && item.rx_idle &&
        idle_gap > {{(TIME_W-CFG_W){1'b0}}, cfg.idle_timeout_ms}) begin
      st_nxt.motor_state = PINS_STOP;
      st_nxt.last_cmd_ms = item.now_ms;
    end
  end

  assign res.motor_pins     = st_nxt.motor_state;
  assign res.buzzer_on      = st_nxt.buzzer_state;
  assign res.fire_alert     = alert;
  assign res.extinguish_req = extinguish;
  assign res.patrol_on      = st_nxt.patrol_active;
  assign res.patrol_phase   = st_nxt.phase;

endmodule

[rtl/patrol_car_motion_controller.sv]
// ---------------------------------------------------------------------------
// patrol_car_motion_controller
// Motion, buzzer and patrol control for a fire patrol car, one pass per item.
// ---------------------------------------------------------------------------
// an item passes the input register, then the result register, which holds
//   the result while the sink stalls
// throughput: one item per cycle while the sink is ready (combinational pass)
// reset: synchronous rst_n clears both pipeline valids and the controller
//   state, and loads the three timing registers with their defaults
module patrol_car_motion_controller import pcmc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pcmc_in_if.sink    in_ch,
  pcmc_out_if.source out_ch,
  pcmc_cfg_if.sink   cfg_ch
);

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  state_t  st_r;
  state_t  st_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    res_valid_r;
  logic    advance;

  pcmc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  pcmc_step u_step (
    .st     (st_r),
    .item   (item_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // held item moves on when the result slot is free or being drained
  assign advance     = item_valid_r && (!res_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.now_ms      <= in_ch.now_ms;
      item_r.flame_seen  <= in_ch.flame_seen;
      item_r.cmd_present <= in_ch.cmd_present;
      item_r.cmd_byte    <= in_ch.cmd_byte;
      item_r.rx_idle     <= in_ch.rx_idle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = res_valid_r;
  assign out_ch.motor_pins     = res_r.motor_pins;
  assign out_ch.buzzer_on      = res_r.buzzer_on;
  assign out_ch.fire_alert     = res_r.fire_alert;
  assign out_ch.extinguish_req = res_r.extinguish_req;
  assign out_ch.patrol_on      = res_r.patrol_on;
  assign out_ch.patrol_phase   = res_r.patrol_phase;

endmodule

[rtl/pcmc_checker.sv]
// ---------------------------------------------------------------------------
// pcmc_port_checks
// Port-level checks on the result channel of the motion controller.
// ---------------------------------------------------------------------------
module pcmc_port_checks import pcmc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PINS_W-1:0]  motor_pins,
  input logic               buzzer_on,
  input logic               fire_alert,
  input logic               extinguish_req,
  input logic               patrol_on,
  input logic [PHASE_W-1:0] patrol_phase
);

  // stalled result keeps its valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({motor_pins, buzzer_on, fire_alert, extinguish_req, patrol_on, patrol_phase}))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // phase is zero exactly when patrol is off, and never past the last turn
  a_phase_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (patrol_on == (patrol_phase != PHASE_STOPPED)) &&
                  (patrol_phase <= PHASE_LAST_TURN))
    else $error("patrol phase inconsistent with patrol status");

  // while patrolling only the forward and right turn patterns drive the motors
  a_patrol_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && patrol_on |-> (motor_pins == PINS_FORWARD) || (motor_pins == PINS_RIGHT))
    else $error("unexpected motor pins during patrol");

  // extinguish command silences the buzzer and ends patrol
  a_extinguish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && extinguish_req |-> !buzzer_on && !patrol_on)
    else $error("extinguish request with buzzer or patrol active");

endmodule

bind patrol_car_motion_controller pcmc_port_checks u_pcmc_port_checks (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .motor_pins     (out_ch.motor_pins),
  .buzzer_on      (out_ch.buzzer_on),
  .fire_alert     (out_ch.fire_alert),
  .extinguish_req (out_ch.extinguish_req),
  .patrol_on      (out_ch.patrol_on),
  .patrol_phase   (out_ch.patrol_phase)
);

[dv/pcmc_checker.sv]
// ---------------------------------------------------------------------------
// pcmc_checker
// Watches the pass, result and register channels of the patrol car motion
// controller, predicts every result from its own copy of the controller
// state and timing registers, and compares each result transfer in order.
// ---------------------------------------------------------------------------
module pcmc_checker import pcmc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pcmc_in_if   in_mon,
  pcmc_out_if  out_mon,
  pcmc_cfg_if  cfg_mon,
  output int   mismatches,
  output int   pending,
  output int   results_checked,
  output int   alerts_seen,
  output int   patrol_loops
);

  localparam int REPORT_MAX = 10;

  state_t    ctl;
  cfg_t      timing;
  result_t   expected_q [$];

  // one control-loop pass against the predicted controller state
  function automatic result_t run_pass(input item_t it);
    result_t           res;
    logic              alert;
    logic              extinguish;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] since_cmd;
    alert      = 1'b0;
    extinguish = 1'b0;

    // flame edges
    if (it.flame_seen && !ctl.flame_prev && ctl.patrol_active) begin
      ctl.buzzer_state  = 1'b1;
      alert             = 1'b1;
      ctl.patrol_active = 1'b0;
      ctl.phase         = PHASE_STOPPED;
      ctl.motor_state   = PINS_STOP;
    end else if (!it.flame_seen && ctl.flame_prev) begin
      ctl.buzzer_state = 1'b0;
    end
    ctl.flame_prev = it.flame_seen;

    // patrol sequencer, a leg ends once elapsed strictly exceeds its length
    elapsed = it.now_ms - ctl.phase_start_ms;
    if (ctl.patrol_active && ctl.phase != PHASE_STOPPED && ctl.phase <= PHASE_LAST_TURN) begin
      if (ctl.phase[0]) begin
        if (elapsed > {16'd0, timing.forward_time_ms}) begin
          ctl.phase          = ctl.phase + 1'b1;
          ctl.phase_start_ms = it.now_ms;
          ctl.motor_state    = PINS_RIGHT;
        end
      end else if (elapsed > {16'd0, timing.turn_time_ms}) begin
        if (ctl.phase == PHASE_LAST_TURN) begin
          ctl.phase    = PHASE_FIRST_LEG;
          patrol_loops = patrol_loops + 1;
        end else begin
          ctl.phase = ctl.phase + 1'b1;
        end
        ctl.phase_start_ms = it.now_ms;
        ctl.motor_state    = PINS_FORWARD;
      end
    end

    // command decode, anything but patrol ends a running patrol
    if (it.cmd_present) begin
      ctl.last_cmd_ms = it.now_ms;
      if (it.cmd_byte != CMD_PATROL && ctl.patrol_active) begin
        ctl.patrol_active = 1'b0;
        ctl.phase         = PHASE_STOPPED;
      end
      case (it.cmd_byte)
        CMD_FORWARD: begin
          ctl.buzzer_state = 1'b0;
          ctl.motor_state  = PINS_FORWARD;
        end
        CMD_BACKWARD: begin
          ctl.buzzer_state = 1'b0;
          ctl.motor_state  = PINS_BACKWARD;
        end
        CMD_LEFT: begin
          ctl.buzzer_state = 1'b0;
          ctl.motor_state  = PINS_LEFT;
        end
        CMD_RIGHT: begin
          ctl.buzzer_state = 1'b0;
          ctl.motor_state  = PINS_RIGHT;
        end
        CMD_STOP: begin
          ctl.buzzer_state = 1'b0;
          ctl.motor_state  = PINS_STOP;
        end
        CMD_PATROL: begin
          if (!ctl.patrol_active) begin
            ctl.patrol_active  = 1'b1;
            ctl.phase          = PHASE_FIRST_LEG;
            ctl.phase_start_ms = it.now_ms;
            ctl.motor_state    = PINS_FORWARD;
          end
        end
        CMD_EXTINGUISH: begin
          ctl.buzzer_state = 1'b0;
          extinguish       = 1'b1;
        end
        default: ;
      endcase
    end

    // manual watchdog
    since_cmd = it.now_ms - ctl.last_cmd_ms;
    if (!ctl.patrol_active && since_cmd > {16'd0, timing.idle_timeout_ms} && it.rx_idle) begin
      ctl.motor_state = PINS_STOP;
      ctl.last_cmd_ms = it.now_ms;
    end

    res.motor_pins     = ctl.motor_state;
    res.buzzer_on      = ctl.buzzer_state;
    res.fire_alert     = alert;
    res.extinguish_req = extinguish;
    res.patrol_on      = ctl.patrol_active;
    res.patrol_phase   = ctl.phase;
    return res;
  endfunction

  always @(posedge clk) begin
    item_t   it;
    result_t got;
    result_t exp_res;
    if (!rst_n) begin
      ctl                    = '0;
      timing.forward_time_ms = FORWARD_TIME_RST;
      timing.turn_time_ms    = TURN_TIME_RST;
      timing.idle_timeout_ms = IDLE_TIMEOUT_RST;
      expected_q.delete();
      mismatches      = 0;
      results_checked = 0;
      alerts_seen     = 0;
      patrol_loops    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.motor_pins     = out_mon.motor_pins;
        got.buzzer_on      = out_mon.buzzer_on;
        got.fire_alert     = out_mon.fire_alert;
        got.extinguish_req = out_mon.extinguish_req;
        got.patrol_on      = out_mon.patrol_on;
        got.patrol_phase   = out_mon.patrol_phase;
        if (expected_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= REPORT_MAX)
            $display("result transfer with nothing expected: pins=%02h buz=%0b alert=%0b",
                     got.motor_pins, got.buzzer_on, got.fire_alert);
        end else begin
          exp_res         = expected_q.pop_front();
          results_checked = results_checked + 1;
          if (exp_res.fire_alert)
            alerts_seen = alerts_seen + 1;
          if (got.motor_pins !== exp_res.motor_pins || got.buzzer_on !== exp_res.buzzer_on ||
              got.fire_alert !== exp_res.fire_alert ||
              got.extinguish_req !== exp_res.extinguish_req ||
              got.patrol_on !== exp_res.patrol_on ||
              got.patrol_phase !== exp_res.patrol_phase) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_MAX)
              $display({"result %0d wrong: expected pins=%02h buz=%0b alert=%0b ext=%0b ",
                        "patrol=%0b phase=%0d, got pins=%02h buz=%0b alert=%0b ext=%0b ",
                        "patrol=%0b phase=%0d"},
                       results_checked, exp_res.motor_pins, exp_res.buzzer_on,
                       exp_res.fire_alert, exp_res.extinguish_req, exp_res.patrol_on,
                       exp_res.patrol_phase, got.motor_pins, got.buzzer_on, got.fire_alert,
                       got.extinguish_req, got.patrol_on, got.patrol_phase);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        it.now_ms      = in_mon.now_ms;
        it.flame_seen  = in_mon.flame_seen;
        it.cmd_present = in_mon.cmd_present;
        it.cmd_byte    = in_mon.cmd_byte;
        it.rx_idle     = in_mon.rx_idle;
        expected_q.push_back(run_pass(it));
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_FORWARD_TIME: timing.forward_time_ms = cfg_mon.data;
          CFG_TURN_TIME:    timing.turn_time_ms    = cfg_mon.data;
          CFG_IDLE_TIMEOUT: timing.idle_timeout_ms = cfg_mon.data;
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Drives control-loop passes and timing register writes into the patrol car
// motion controller with random source gaps and sink stalls; a checker
// module beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module testbench;
  import pcmc_pkg::*;

  localparam int LATENCY        = 2;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst_n;

  pcmc_in_if  in_if ();
  pcmc_out_if out_if ();
  pcmc_cfg_if cfg_if ();

  int mismatches;
  int pending;
  int results_checked;
  int alerts_seen;
  int patrol_loops;

  logic             gaps_on;
  logic             stalls_on;
  logic [CFG_W-1:0] cur_fwd;
  logic [CFG_W-1:0] cur_turn;
  int               settings_used;
  int               quiet_cycles;

  patrol_car_motion_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  pcmc_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_if),
    .out_mon         (out_if),
    .cfg_mon         (cfg_if),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .alerts_seen     (alerts_seen),
    .patrol_loops    (patrol_loops)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result sink with random stall bursts
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ends the run if nothing transfers for too long
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // entered and left at a falling edge; valid stays high for the next pass
  task automatic send_pass(input logic [TIME_W-1:0] now, input logic flame,
                           input logic cmd_valid, input logic [CMD_W-1:0] cmd,
                           input logic rx);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.now_ms      <= now;
    in_if.flame_seen  <= flame;
    in_if.cmd_present <= cmd_valid;
    in_if.cmd_byte    <= cmd;
    in_if.rx_idle     <= rx;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and let every pending result come back
  task automatic drain;
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_timing(input logic [CFG_W-1:0] fwd, input logic [CFG_W-1:0] turn,
                              input logic [CFG_W-1:0] idle);
    logic [CIDX_W-1:0] regs [3];
    logic [CFG_W-1:0]  vals [3];
    regs = '{CFG_FORWARD_TIME, CFG_TURN_TIME, CFG_IDLE_TIMEOUT};
    vals = '{fwd, turn, idle};
    for (int k = 0; k < 3; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= regs[k];
      cfg_if.data  <= vals[k];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_if.valid  <= 1'b0;
    cur_fwd       = fwd;
    cur_turn      = turn;
    settings_used = settings_used + 1;
  endtask

  // mostly small time steps so patrols run through their legs, with rare
  // commands, flame toggles and occasional jumps anywhere in the time range
  task automatic random_run(input int n_items, input logic [TIME_W-1:0] t0);
    logic [TIME_W-1:0] t;
    logic              flame;
    logic              cmd_valid;
    logic [CMD_W-1:0]  cmd;
    logic [CMD_W-1:0]  known [7];
    int                span;
    int                roll;
    known = '{CMD_FORWARD, CMD_BACKWARD, CMD_LEFT, CMD_RIGHT, CMD_STOP, CMD_PATROL,
              CMD_EXTINGUISH};
    t     = t0;
    flame = 1'b0;
    span  = (int'(cur_fwd) + int'(cur_turn)) / 4 + 2;
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 2)
        t = $urandom();
      else if (roll < 5)
        t = t + $urandom_range(0, 262143);
      else
        t = t + $urandom_range(0, span);
      if ($urandom_range(0, 19) == 0)
        flame = ~flame;
      cmd_valid = ($urandom_range(0, 99) < 15);
      roll      = $urandom_range(0, 99);
      if (roll < 40)
        cmd = CMD_PATROL;
      else if (roll < 85)
        cmd = known[$urandom_range(0, 6)];
      else
        cmd = CMD_W'($urandom_range(0, 255));
      send_pass(t, flame, cmd_valid, cmd, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [TIME_W-1:0] t;
    in_if.valid       = 1'b0;
    in_if.now_ms      = '0;
    in_if.flame_seen  = 1'b0;
    in_if.cmd_present = 1'b0;
    in_if.cmd_byte    = '0;
    in_if.rx_idle     = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_FORWARD_TIME;
    cfg_if.data       = '0;
    gaps_on           = 1'b1;
    stalls_on         = 1'b1;
    cur_fwd           = FORWARD_TIME_RST;
    cur_turn          = TURN_TIME_RST;
    settings_used     = 1;
    quiet_cycles      = 0;
    rst_n             = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed passes on the reset timing: a full patrol loop with exact
    // boundaries, flame edges, every command, the watchdog and a leg across a wrap
    send_pass(32'd0, 1'b0, 1'b0, 8'h00, 1'b0);
    send_pass(32'd5, 1'b0, 1'b1, CMD_PATROL, 1'b1);
    t = 32'd5 + FORWARD_TIME_RST;
    send_pass(t, 1'b0, 1'b0, 8'h00, 1'b1);
    for (int k = 0; k < 8; k++) begin
      t = t + 1 + ((k % 2 == 0) ? 32'd0 : {16'd0, TURN_TIME_RST});
      if (k % 2 == 0 && k != 0)
        t = t + FORWARD_TIME_RST;
      send_pass(t, 1'b0, 1'b0, 8'hFF, 1'b1);
    end
    send_pass(t + 1, 1'b0, 1'b1, CMD_PATROL, 1'b0);
    send_pass(t + 2, 1'b1, 1'b0, 8'h00, 1'b0);
    send_pass(t + 3, 1'b1, 1'b0, 8'h00, 1'b0);
    send_pass(t + 4, 1'b0, 1'b0, 8'h00, 1'b0);
    send_pass(t + 5, 1'b1, 1'b0, 8'h00, 1'b0);
    send_pass(t + 6, 1'b0, 1'b1, CMD_FORWARD, 1'b0);
    send_pass(t + 7, 1'b0, 1'b1, CMD_BACKWARD, 1'b0);
    send_pass(t + 8, 1'b0, 1'b1, CMD_LEFT, 1'b0);
    send_pass(t + 9, 1'b0, 1'b1, CMD_RIGHT, 1'b0);
    send_pass(t + 10, 1'b0, 1'b1, CMD_EXTINGUISH, 1'b0);
    send_pass(t + 11, 1'b0, 1'b1, CMD_STOP, 1'b0);
    send_pass(t + 12, 1'b0, 1'b1, CMD_FORWARD, 1'b0);
    send_pass(t + 13, 1'b0, 1'b1, 8'hFF, 1'b0);
    send_pass(t + 600, 1'b0, 1'b0, 8'h00, 1'b1);
    send_pass(32'hFFFF_FF00, 1'b0, 1'b1, CMD_PATROL, 1'b1);
    send_pass(32'h0000_0F00, 1'b0, 1'b0, 8'h00, 1'b1);
    send_pass(32'h0000_0F01, 1'b0, 1'b1, 8'h00, 1'b1);
    send_pass(32'h0000_1200, 1'b0, 1'b0, 8'h00, 1'b1);
    drain();

    write_timing(16'd0, 16'd0, 16'd0);
    random_run(150, 32'd100);
    drain();
    write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_run(150, 32'hFFFF_8000);
    drain();
    write_timing(16'd37, 16'd12, 16'd25);
    random_run(200, $urandom());
    drain();
    write_timing(16'd1, 16'hFFFF, 16'd0);
    random_run(120, $urandom());
    drain();
    write_timing(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(0, 200)),
                 CFG_W'($urandom_range(0, 200)));
    random_run(150, $urandom());
    drain();

    // last part at full rate on both sides
    write_timing(FORWARD_TIME_RST, TURN_TIME_RST, IDLE_TIMEOUT_RST);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_run(150, $urandom());
    drain();

    $display("checked %0d passes under %0d timing settings", results_checked, settings_used);
    $display("predicted %0d fire alerts and %0d complete patrol loops",
             alerts_seen, patrol_loops);
    if (mismatches == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
